### hw/rtl/nbcd_pkg.sv
// shared constants, types and helpers for the nearest black cell distance block
package nbcd_pkg;

    localparam int MAX_SIDE = 64;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W   = COORD_W + 1;
    localparam int DIST_W   = 7;
    localparam int CAND_W   = DIST_W + 1;
    localparam int GROUP    = 8;
    localparam int NGROUP   = MAX_SIDE / GROUP;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // register indexes on the configuration port
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_BOARD_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_ROW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_COL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] row;
    } row_tag_t;

    typedef struct packed {
        logic              vld;
        logic [CAND_W-1:0] span;
    } cand_t;

    function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### hw/rtl/nbcd_row_min.sv
// pipelined nearest black cell search over one board row
module nbcd_row_min
    import nbcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  row_tag_t            tag_in,
    input  logic [MAX_SIDE-1:0] row_bits,
    input  logic [SIDE_W-1:0]   side,
    input  logic [COORD_W-1:0]  qr,
    input  logic [COORD_W-1:0]  qc,
    output cand_t               cand,
    output logic                busy
);

    logic [DIST_W-1:0] cell_dist [MAX_SIDE];
    logic [DIST_W-1:0] gmin_next [NGROUP];
    logic [DIST_W-1:0] gmin_reg  [NGROUP];
    row_tag_t          mid_tag_reg;
    logic [DIST_W-1:0] colmin;
    cand_t             cand_next;
    cand_t             cand_reg;

    // column distance of every black cell inside the board, sentinel elsewhere
    always_comb
    begin
        for (int c = 0; c < MAX_SIDE; c++)
        begin
            if (row_bits[c] && (SIDE_W'(c) < side))
                cell_dist[c] = {1'b0, absdiff(qc, COORD_W'(c))};
            else
                cell_dist[c] = DIST_MAX;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            gmin_next[g] = DIST_MAX;
            for (int k = 0; k < GROUP; k++)
            begin
                if (cell_dist[g*GROUP + k] < gmin_next[g])
                    gmin_next[g] = cell_dist[g*GROUP + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGROUP; g++)
            gmin_reg[g] <= gmin_next[g];
    end

    always_comb
    begin
        colmin = DIST_MAX;
        for (int g = 0; g < NGROUP; g++)
        begin
            if (gmin_reg[g] < colmin)
                colmin = gmin_reg[g];
        end
        cand_next.vld = mid_tag_reg.vld;
        if (colmin == DIST_MAX)
            cand_next.span = '1;
        else
            cand_next.span = CAND_W'(colmin) + CAND_W'(absdiff(qr, mid_tag_reg.row));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_tag_reg <= '0;
            cand_reg    <= '0;
        end
        else
        begin
            mid_tag_reg <= tag_in;
            cand_reg    <= cand_next;
        end
    end

    assign cand = cand_reg;
    assign busy = mid_tag_reg.vld | cand_reg.vld;

endmodule

### hw/rtl/nearest_black_cell_distance.sv
// top level: nearest black cell distance query over a painted square board
//
// An in-range query passes from acceptance to the result register through the
// scan, drain and finish states: the black map is held as one 64-bit row per
// memory word and the scan reads one row per cycle, followed by a short drain
// of the row minimum pipeline and the finish step, which writes the painted row
// back as the result register loads. A query outside the board goes straight
// to the finish step and paints nothing. One query is worked on at a time; a
// new query is taken once the previous one has been handed to the result
// register, even while that result still waits to be taken. The map needs no
// clearing pass after reset: a flag per row marks written rows, and a row never
// written reads as all white. The user must write configuration registers over
// the APB-style port only while idle; the block itself does not enforce this.
module nearest_black_cell_distance
    import nbcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // query channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [COORD_W-1:0]  query_row,
    input  logic [COORD_W-1:0]  query_col,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DIST_W-1:0]   nearest_distance,
    output logic                out_of_range,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // configuration registers
    logic [SIDE_W-1:0]  board_size_reg;
    logic [COORD_W-1:0] start_row_reg;
    logic [COORD_W-1:0] start_col_reg;
    logic               cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // control
    state_t             state_reg, state_next;
    logic [COORD_W-1:0] rd_row_reg;
    logic [COORD_W-1:0] qr_reg;
    logic [COORD_W-1:0] qc_reg;
    logic [SIDE_W-1:0]  side_reg;
    logic               oor_reg;
    logic [CAND_W-1:0]  best_reg;
    logic [MAX_SIDE-1:0] cap_row_reg;

    // black map and row written flags
    logic [MAX_SIDE-1:0] map_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] mem_q_reg;
    logic [MAX_SIDE-1:0] row_written_reg;
    logic                s1_written_reg;
    row_tag_t            s1_tag_reg;
    logic [MAX_SIDE-1:0] s1_bits;

    // result register
    logic               out_valid_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_oor_reg;

    // fsm outputs
    logic               accept;
    logic               rd_issue;
    logic               finish_load;

    // query preparation
    logic [SIDE_W-1:0]  side;
    logic [COORD_W-1:0] sr;
    logic [COORD_W-1:0] sc;
    logic               q_oor;
    logic [CAND_W-1:0]  start_dist;
    logic [SIDE_W-1:0]  last_row;

    cand_t              cand;
    logic               pipe_busy;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_size_reg <= SIDE_W'(MAX_SIDE);
            start_row_reg  <= '0;
            start_col_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BOARD_SIZE: board_size_reg <= pwdata[SIDE_W-1:0];
                REG_START_ROW:  start_row_reg  <= pwdata[COORD_W-1:0];
                REG_START_COL:  start_col_reg  <= pwdata[COORD_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BOARD_SIZE: prdata = 32'(board_size_reg);
            REG_START_ROW:  prdata = 32'(start_row_reg);
            REG_START_COL:  prdata = 32'(start_col_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- query preparation ----------------
    // side in use is clamped to one..max, start cell saturated into the board
    always_comb
    begin
        if (board_size_reg == '0)
            side = SIDE_W'(1);
        else if (board_size_reg > SIDE_W'(MAX_SIDE))
            side = SIDE_W'(MAX_SIDE);
        else
            side = board_size_reg;

        sr = ({1'b0, start_row_reg} < side) ? start_row_reg : COORD_W'(side - SIDE_W'(1));
        sc = ({1'b0, start_col_reg} < side) ? start_col_reg : COORD_W'(side - SIDE_W'(1));

        q_oor = ({1'b0, query_row} >= side) || ({1'b0, query_col} >= side);
        start_dist = CAND_W'(absdiff(query_row, sr)) + CAND_W'(absdiff(query_col, sc));
    end

    assign last_row = side_reg - SIDE_W'(1);

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        accept      = 1'b0;
        rd_issue    = 1'b0;
        finish_load = 1'b0;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    accept     = 1'b1;
                    state_next = q_oor ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_issue = 1'b1;
                if ({1'b0, rd_row_reg} == last_row)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // best distance is final once the row pipeline is empty
                if (!s1_tag_reg.vld && !pipe_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    finish_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // query context and running best
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qr_reg     <= query_row;
            qc_reg     <= query_col;
            side_reg   <= side;
            oor_reg    <= q_oor;
            best_reg   <= start_dist;
            rd_row_reg <= '0;
        end
        else
        begin
            if (rd_issue)
                rd_row_reg <= rd_row_reg + COORD_W'(1);
            if (cand.vld && (cand.span < best_reg))
                best_reg <= cand.span;
        end
        // keep the queried row for the paint write
        if (s1_tag_reg.vld && (s1_tag_reg.row == qr_reg))
            cap_row_reg <= s1_bits;
    end

    // ---------------- black map memory ----------------
    always_ff @(posedge clk)
    begin
        if (finish_load && !oor_reg)
            map_mem[qr_reg] <= cap_row_reg | (MAX_SIDE'(1) << qc_reg);
        mem_q_reg <= map_mem[rd_row_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_written_reg <= '0;
            s1_tag_reg      <= '0;
        end
        else
        begin
            if (finish_load && !oor_reg)
                row_written_reg[qr_reg] <= 1'b1;
            s1_tag_reg.vld <= rd_issue;
            s1_tag_reg.row <= rd_row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_written_reg <= row_written_reg[rd_row_reg];
    end

    // a row never written reads as all white
    assign s1_bits = s1_written_reg ? mem_q_reg : '0;

    nbcd_row_min u_row_min (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (s1_tag_reg),
        .row_bits (s1_bits),
        .side     (side_reg),
        .qr       (qr_reg),
        .qc       (qc_reg),
        .cand     (cand),
        .busy     (pipe_busy)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish_load)
        begin
            out_oor_reg <= oor_reg;
            if (oor_reg)
                out_dist_reg <= '0;
            else if (best_reg > CAND_W'(DIST_MAX))
                out_dist_reg <= DIST_MAX;
            else
                out_dist_reg <= best_reg[DIST_W-1:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign nearest_distance = out_dist_reg;
    assign out_of_range     = out_oor_reg;

endmodule

### tb/nearest_black_cell_distance_test.sv
// testbench for the nearest black cell distance block: directed table, random phases, scoreboard
module nearest_black_cell_distance_test
    import nbcd_pkg::*;
;

    // run shape
    localparam int RANDOM_ITEMS    = 1130;
    localparam int CALM_ITEMS      = 150;      // tail of the run without any idling
    localparam int HOLD_OFF_CYCLES = 400;      // long receiver stall, fills the block up
    localparam int SETTLE_CYCLES   = 8;        // quiet time before a register write
    localparam int LIMIT_CYCLES    = 1000000;

    // one answer as the block should hand it out
    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              oor;
    } answer_t;

    // a row of the directed table: either a query or a register write
    typedef enum logic {DIR_QUERY, DIR_WRITE} dir_kind_t;
    typedef struct {
        dir_kind_t              kind;
        logic [REG_IDX_W-1:0]   idx;
        int                     value;
        int                     row;
        int                     col;
        bit                     known;     // answer typed in the table rather than predicted
        int                     distance;
        bit                     oor;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [COORD_W-1:0]  query_row = '0;
    logic [COORD_W-1:0]  query_col = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DIST_W-1:0]   nearest_distance;
    logic                out_of_range;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [3:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state: own copy of the registers and of the painted cells
    logic [6:0]          cfg_board_size = 7'd64;
    logic [COORD_W-1:0]  cfg_start_row  = '0;
    logic [COORD_W-1:0]  cfg_start_col  = '0;
    bit [MAX_SIDE-1:0]   black_cells [MAX_SIDE];

    answer_t             pending_answers[$];
    int                  mismatch_count = 0;
    int                  failures = 0;
    int                  cycle_count = 0;
    bit                  calm = 1'b0;
    bit                  hold_off_pending = 1'b0;
    dir_row_t            directed_rows[$];

    nearest_black_cell_distance i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .query_row        (query_row),
        .query_col        (query_col),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .nearest_distance (nearest_distance),
        .out_of_range     (out_of_range),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog, the run can never hang
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[nearest_black_cell_distance] ERROR");
            $finish;
        end
    end

    // side of the board in use: zero counts as one, anything above the maximum saturates
    function automatic int side_in_use();
        int side;
        side = int'(cfg_board_size);
        if (side > MAX_SIDE)
            side = MAX_SIDE;
        if (side < 1)
            side = 1;
        return side;
    endfunction

    function automatic int distance_between(int r0, int c0, int r1, int c1);
        return ((r0 > r1) ? r0 - r1 : r1 - r0) + ((c0 > c1) ? c0 - c1 : c1 - c0);
    endfunction

    // least manhattan distance to a black cell on the board in use, then paint the query cell
    function automatic void paint_and_measure(input int row, input int col,
                                              output logic [DIST_W-1:0] distance,
                                              output logic oor);
        int side;
        int sr;
        int sc;
        int best;
        int d;
        side = side_in_use();
        // start cell clipped onto the board so there is always one black cell
        sr = (cfg_start_row < side) ? int'(cfg_start_row) : side - 1;
        sc = (cfg_start_col < side) ? int'(cfg_start_col) : side - 1;
        if (row >= side || col >= side)
        begin
            // outside the board: flag only, nothing painted
            distance = '0;
            oor      = 1'b1;
            return;
        end
        best = distance_between(row, col, sr, sc);
        // painted cells outside a shrunk board stay stored but do not count
        for (int r = 0; r < side; r++)
            for (int c = 0; c < side; c++)
                if (black_cells[r][c])
                begin
                    d = distance_between(row, col, r, c);
                    if (d < best)
                        best = d;
                end
        if (best > int'(DIST_MAX))
            best = int'(DIST_MAX);
        black_cells[row][col] = 1'b1;
        distance = best[DIST_W-1:0];
        oor      = 1'b0;
    endfunction

    // table helpers
    function automatic dir_row_t ask(int row, int col);
        return '{DIR_QUERY, REG_BOARD_SIZE, 0, row, col, 1'b0, 0, 1'b0};
    endfunction

    function automatic dir_row_t ask_known(int row, int col, int distance, bit oor);
        return '{DIR_QUERY, REG_BOARD_SIZE, 0, row, col, 1'b1, distance, oor};
    endfunction

    function automatic dir_row_t set_reg(logic [REG_IDX_W-1:0] idx, int value);
        return '{DIR_WRITE, idx, value, 0, 0, 1'b0, 0, 1'b0};
    endfunction

    // offer one query transaction, optionally after a random gap, and book its answer
    task automatic offer_query(input int row, input int col, input bit known,
                               input int distance, input bit oor);
        answer_t            ans;
        logic [DIST_W-1:0]  p_dist;
        logic               p_oor;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        query_row <= row[COORD_W-1:0];
        query_col <= col[COORD_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge: predict against the configuration in force
        paint_and_measure(row, col, p_dist, p_oor);
        ans.distance = known ? distance[DIST_W-1:0] : p_dist;
        ans.oor      = known ? oor : p_oor;
        pending_answers.insert(pending_answers.size(), ans);
    endtask

    // drop valid and wait until every booked answer has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // register write over the apb-style port, only with the block idle
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input int value);
        wait_for_drain();
        // the painted row is written back along with the answer, give it time to settle
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BOARD_SIZE: cfg_board_size = value[6:0];
            REG_START_ROW:  cfg_start_row  = value[COORD_W-1:0];
            REG_START_COL:  cfg_start_col  = value[COORD_W-1:0];
            default: ;
        endcase
    endtask

    // result side: random stall bursts, quiet stretches, and one long hold-off
    initial
    begin : result_side
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                // long stall while the sender keeps offering, so the block backs up
                hold_off_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // scoreboard: every accepted answer against the oldest booked one
    always @(posedge clk)
    begin : answer_check
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                failures++;
                if (mismatch_count < 10)
                    $display("unexpected answer: distance %0d out_of_range %0d",
                             nearest_distance, out_of_range);
                mismatch_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (nearest_distance !== want.distance || out_of_range !== want.oor)
                begin
                    failures++;
                    if (mismatch_count < 10)
                        $display("answer mismatch: distance exp %0d got %0d, %s exp %0d got %0d",
                                 want.distance, nearest_distance, "out_of_range",
                                 want.oor, out_of_range);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int random_sent;
        int phase;
        int side;
        int size;
        int phase_items;
        int row;
        int col;

        foreach (black_cells[r])
            black_cells[r] = '0;

        // directed part, defaults first: board 64, start cell in the corner
        directed_rows = '{
            ask_known(0, 0, 0, 1'b0),          // the start cell itself
            ask_known(63, 63, 126, 1'b0),      // far corner, largest distance
            ask_known(63, 63, 0, 1'b0),        // already painted
            ask(0, 63),
            ask(42, 21),
            ask(21, 42),
            // shrink the board, start cell beyond it gets clipped to the corner
            set_reg(REG_BOARD_SIZE, 10),
            set_reg(REG_START_ROW, 63),
            set_reg(REG_START_COL, 63),
            ask_known(9, 9, 0, 1'b0),          // clipped start cell
            ask(5, 2),                         // painted cells off the board ignored
            ask_known(10, 3, 0, 1'b1),
            ask_known(3, 10, 0, 1'b1),
            ask_known(63, 63, 0, 1'b1),        // painted, but off the shrunk board
            // zero board size behaves as a single cell
            set_reg(REG_BOARD_SIZE, 0),
            ask_known(0, 0, 0, 1'b0),
            ask_known(0, 1, 0, 1'b1),
            ask_known(1, 0, 0, 1'b1),
            // oversize saturates to the full board, old paint counts again
            set_reg(REG_BOARD_SIZE, 127),
            ask_known(63, 63, 0, 1'b0),
            ask(31, 32),
            ask(0, 42)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == DIR_WRITE)
                write_register(directed_rows[i].idx, directed_rows[i].value);
            else
                offer_query(directed_rows[i].row, directed_rows[i].col,
                            directed_rows[i].known, directed_rows[i].distance,
                            directed_rows[i].oor);
        end

        // random phases: fresh settings each time, all three registers written
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       size = 0;
                1:       size = $urandom_range(65, 127);
                2:       size = 64;
                3:       size = 1;
                4, 5:    size = $urandom_range(2, 8);
                default: size = $urandom_range(9, 64);
            endcase
            write_register(REG_BOARD_SIZE, size);
            side = side_in_use();
            // now and then a start cell off the board to exercise the clipping
            write_register(REG_START_ROW, ($urandom_range(0, 4) == 0) ?
                           $urandom_range(0, 63) : $urandom_range(0, side - 1));
            write_register(REG_START_COL, ($urandom_range(0, 4) == 0) ?
                           $urandom_range(0, 63) : $urandom_range(0, side - 1));

            if (phase == 1)
                hold_off_pending = 1'b1;

            phase_items = $urandom_range(30, 120);
            for (int k = 0; k < phase_items && random_sent < RANDOM_ITEMS; k++)
            begin
                calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
                // mostly cells on the board, the rest anywhere in the field range
                if ($urandom_range(0, 6) == 0)
                begin
                    row = $urandom_range(0, 63);
                    col = $urandom_range(0, 63);
                end
                else
                begin
                    row = $urandom_range(0, side - 1);
                    col = $urandom_range(0, side - 1);
                end
                offer_query(row, col, 1'b0, 0, 1'b0);
                random_sent++;
            end
            phase++;
        end

        // let everything come back, then allow for one more full scan
        wait_for_drain();
        repeat (MAX_SIDE + 5 + 16) @(posedge clk);
        if (failures == 0 && pending_answers.size() == 0)
            $display("[nearest_black_cell_distance] OK");
        else
            $display("[nearest_black_cell_distance] ERROR");
        $finish;
    end

endmodule
